// ----- sv/itf_pkg.sv -----
// itf_pkg: shared types, constants and the digit character function of the integer to text formatter.
// No dependencies; imported by every module of the block.
package itf_pkg;

    localparam int MAX_CHARS_DEF   = 64;
    localparam int DIGIT_DEPTH_DEF = 64;
    localparam int Q_DEPTH         = 2;
    localparam int DIV_STEPS       = 8;   // quotient bits per cycle
    localparam int LEN_W           = 8;   // segment boundaries, total length

    // format flag bit positions
    localparam int FLAG_LJUST      = 0;
    localparam int FLAG_FORCE_SIGN = 1;
    localparam int FLAG_BLANK_SIGN = 2;
    localparam int FLAG_PREFIX     = 3;
    localparam int FLAG_ZPAD       = 4;
    localparam int FLAG_LOWER      = 5;
    localparam int FLAG_SIGNED     = 6;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic [63:0] mag;
        logic [4:0]  base;
        logic [2:0]  sh;       // log2 of base, 0 when not a power of two
        logic [3:0]  mask;
        logic [6:0]  width;
        logic [6:0]  prec;
        logic        sign_len;
        logic [7:0]  sign_ch;
        logic [1:0]  pfx_len;
        logic        left;
        logic        zpad;     // already cancelled by left alignment
        logic        lower;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_EMIT
    } t_back_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] c;
        begin
            if (d < 4'd10) c = CH_ZERO + {4'b0, d};
            else if (lower) c = 8'h61 + {4'b0, d - 4'd10};
            else c = 8'h41 + {4'b0, d - 4'd10};
            return c;
        end
    endfunction

endpackage

// ----- sv/itf_front.sv -----
// itf_front: accepts input items, drops bad bases, works out sign, magnitude and prefix.
// Depends on itf_pkg.
module itf_front (
    input  logic [63:0]          i_value,
    input  logic [4:0]           i_base,
    input  logic [6:0]           i_width,
    input  logic [6:0]           i_precision,
    input  logic [6:0]           i_format_flags,
    input  logic                 i_valid,
    input  itf_pkg::t_q_stat     i_q_stat,
    output logic                 o_stall,
    output logic                 o_push,
    output itf_pkg::t_item       o_item
);
    import itf_pkg::*;

    logic base_ok;
    logic [2:0] sh;

    assign o_stall = i_q_stat.full;
    assign base_ok = (i_base >= 5'd2) && (i_base <= 5'd16);
    assign o_push  = i_valid && !i_q_stat.full && base_ok;

    always_comb begin
        unique case (i_base)
            5'd2:    sh = 3'd1;
            5'd4:    sh = 3'd2;
            5'd8:    sh = 3'd3;
            5'd16:   sh = 3'd4;
            default: sh = 3'd0;
        endcase
    end

    always_comb begin
        o_item          = '0;
        o_item.mag      = i_value;
        o_item.base     = i_base;
        o_item.sh       = sh;
        o_item.mask     = 4'(i_base - 5'd1);
        o_item.width    = i_width;
        o_item.prec     = i_precision;
        o_item.left     = i_format_flags[FLAG_LJUST];
        o_item.zpad     = i_format_flags[FLAG_ZPAD] && !i_format_flags[FLAG_LJUST];
        o_item.lower    = i_format_flags[FLAG_LOWER];
        if (i_format_flags[FLAG_SIGNED]) begin
            if (i_value[63]) begin
                o_item.sign_len = 1'b1;
                o_item.sign_ch  = CH_MINUS;
                o_item.mag      = 64'd0 - i_value;
            end else if (i_format_flags[FLAG_FORCE_SIGN]) begin
                o_item.sign_len = 1'b1;
                o_item.sign_ch  = CH_PLUS;
            end else if (i_format_flags[FLAG_BLANK_SIGN]) begin
                o_item.sign_len = 1'b1;
                o_item.sign_ch  = CH_SPACE;
            end
        end
        if (i_format_flags[FLAG_PREFIX]) begin
            if (i_base == 5'd16) o_item.pfx_len = 2'd2;
            else if (i_base == 5'd8) o_item.pfx_len = 2'd1;
        end
    end

endmodule

// ----- sv/itf_queue.sv -----
// itf_queue: short queue of classified items between front and back.
// Depends on itf_pkg.
module itf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  itf_pkg::t_item       i_item,
    input  logic                 i_pop,
    output itf_pkg::t_item       o_item,
    output itf_pkg::t_q_stat     o_stat
);
    import itf_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    t_item          r_mem [Q_DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == PW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == PW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

endmodule

// ----- sv/itf_back.sv -----
// itf_back: digit extraction, segment layout and character emission.
// Depends on itf_pkg.
module itf_back #(
    parameter int MAX_CHARS   = itf_pkg::MAX_CHARS_DEF,
    parameter int DIGIT_DEPTH = itf_pkg::DIGIT_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itf_pkg::t_item       i_item,
    input  itf_pkg::t_q_stat     i_q_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_text_char,
    output logic                 o_last,
    output logic                 o_truncated
);
    import itf_pkg::*;

    localparam int CW  = $clog2(MAX_CHARS + 1);
    localparam int NDW = $clog2(DIGIT_DEPTH + 1);
    localparam int SW  = $clog2(DIV_STEPS);

    t_back_state      r_state, n_state;
    t_item            r_it;
    logic [63:0]      r_mag;
    logic [3:0]       r_rem;
    logic [SW-1:0]    r_sub;
    logic [NDW-1:0]   r_ndig;
    logic [3:0]       r_dig [DIGIT_DEPTH];
    logic [6:0]       r_lead, r_pad, r_trail, r_precz;
    logic [LEN_W-1:0] r_b1, r_b2, r_b3, r_b5, r_b6;
    logic [CW-1:0]    r_count;
    logic             r_trunc;
    logic [CW-1:0]    r_pos;
    logic             r_out_valid;
    logic [7:0]       r_char;
    logic             r_last, r_trunc_out;

    logic [63:0]      q_next;
    logic [3:0]       rem_next;
    logic             dig_done, conv_done, emit_go, emit_end;
    logic [3:0]       dig_val;
    logic [63:0]      mag_after;
    logic [6:0]       pe;
    logic [8:0]       room;
    logic [6:0]       rpos;
    logic [LEN_W-1:0] b1, b2, b3, b4, b5, b6, total, pos_w;
    logic [7:0]       ch;
    logic             in_dig;

    // eight restoring division steps per cycle, remainder stays below base
    always_comb begin
        logic [4:0] t;
        logic [3:0] rem;
        logic [63:0] q;
        rem = r_rem;
        q   = r_mag;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {rem, q[63]};
            q = {q[62:0], 1'b0};
            if (t >= r_it.base) begin
                t    = t - r_it.base;
                q[0] = 1'b1;
            end
            rem = t[3:0];
        end
        q_next   = q;
        rem_next = rem;
    end

    always_comb begin
        if (r_it.sh != 3'd0) begin
            dig_done  = 1'b1;
            dig_val   = r_mag[3:0] & r_it.mask;
            mag_after = r_mag >> r_it.sh;
        end else begin
            dig_done  = (r_sub == SW'(DIV_STEPS - 1));
            dig_val   = rem_next;
            mag_after = q_next;
        end
    end

    // layout: lead spaces, sign, prefix, pad, precision zeros, digits, trailing spaces
    always_comb begin
        pe    = (r_it.prec > 7'(r_ndig)) ? r_it.prec : 7'(r_ndig);
        room  = {2'b0, r_it.width} - {8'b0, r_it.sign_len} - {7'b0, r_it.pfx_len}
                - {2'b0, pe};
        rpos  = (room[8] || room == 9'd0) ? 7'd0 : room[6:0];
        b1    = LEN_W'(r_lead);
        b2    = b1 + LEN_W'(r_it.sign_len);
        b3    = b2 + LEN_W'(r_it.pfx_len);
        b4    = b3 + LEN_W'(r_pad);
        b5    = b4 + LEN_W'(r_precz);
        b6    = b5 + LEN_W'(r_ndig);
        total = b6 + LEN_W'(r_trail);
        pos_w = LEN_W'(r_pos);
    end

    always_comb begin
        in_dig = 1'b0;
        if (pos_w < r_b1) ch = CH_SPACE;
        else if (pos_w < r_b2) ch = r_it.sign_ch;
        else if (pos_w < r_b3) begin
            if (r_it.pfx_len == 2'd1 || pos_w == r_b2) ch = CH_ZERO;
            else ch = r_it.lower ? CH_X_LO : CH_X_UP;
        end else if (pos_w < r_b5) ch = CH_ZERO;
        else if (pos_w < r_b6) begin
            ch     = digit_char(r_dig[0], r_it.lower);
            in_dig = 1'b1;
        end else ch = CH_SPACE;
    end

    // control outputs
    always_comb begin
        o_pop     = (r_state == ST_IDLE) && !i_q_stat.empty;
        conv_done = (r_state == ST_CONV) && dig_done &&
                    (mag_after == 64'd0 || r_ndig == NDW'(DIGIT_DEPTH - 1));
        emit_go   = (r_state == ST_EMIT) && (!r_out_valid || !i_stall);
        emit_end  = emit_go && (r_pos == r_count - 1'b1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (o_pop) n_state = ST_CONV;
            ST_CONV:    if (conv_done) n_state = ST_SETUP_A;
            ST_SETUP_A: n_state = ST_SETUP_B;
            ST_SETUP_B: n_state = ST_EMIT;
            ST_EMIT:    if (emit_end) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (!r_out_valid || !i_stall) r_out_valid <= emit_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_it   <= i_item;
            r_mag  <= i_item.mag;
            r_rem  <= '0;
            r_sub  <= '0;
            r_ndig <= '0;
        end
        if (r_state == ST_CONV) begin
            if (dig_done) begin
                r_mag  <= mag_after;
                r_rem  <= '0;
                r_sub  <= '0;
                r_ndig <= r_ndig + 1'b1;
                r_dig[0] <= dig_val;
                for (int i = 1; i < DIGIT_DEPTH; i++) r_dig[i] <= r_dig[i-1];
            end else begin
                // only the divider path gets here
                r_sub <= r_sub + 1'b1;
                r_mag <= q_next;
                r_rem <= rem_next;
            end
        end
        if (r_state == ST_SETUP_A) begin
            r_precz <= pe - 7'(r_ndig);
            r_lead  <= (!r_it.left && !r_it.zpad) ? rpos : 7'd0;
            r_pad   <= r_it.zpad ? rpos : 7'd0;
            r_trail <= r_it.left ? rpos : 7'd0;
        end
        if (r_state == ST_SETUP_B) begin
            r_b1    <= b1;
            r_b2    <= b2;
            r_b3    <= b3;
            r_b5    <= b5;
            r_b6    <= b6;
            r_count <= (total > LEN_W'(MAX_CHARS)) ? CW'(MAX_CHARS) : CW'(total);
            r_trunc <= (total > LEN_W'(MAX_CHARS));
            r_pos   <= '0;
        end
        if (emit_go) begin
            r_char      <= ch;
            r_last      <= emit_end;
            r_trunc_out <= emit_end && r_trunc;
            r_pos       <= r_pos + 1'b1;
            if (in_dig) begin
                for (int i = 0; i < DIGIT_DEPTH - 1; i++) r_dig[i] <= r_dig[i+1];
                r_dig[DIGIT_DEPTH-1] <= 4'd0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_text_char = r_char;
    assign o_last      = r_last;
    assign o_truncated = r_trunc_out;

endmodule

// ----- sv/integer_to_text_formatter_core.sv -----
// integer_to_text_formatter_core: printf style integer formatter, text emitted one character at a time.
// Order with the back end idle: pop from the queue, digit conversion, layout (ST_SETUP_A,
// ST_SETUP_B), then the output register that shows the first character. Bases 2/4/8/16 take
// digits by shift and mask, other bases use the shared restoring divider (8 quotient bits a
// cycle; base 3 worst, 41 digits). Throughput: 1 character per cycle while emitting and the
// receiver does not stall; a 2-deep queue takes the next requests while the back end works.
// Reset: synchronous, active low, clears the queue, the back-end state machine and output valid.
module integer_to_text_formatter_core #(
    parameter int MAX_CHARS   = itf_pkg::MAX_CHARS_DEF,
    parameter int DIGIT_DEPTH = itf_pkg::DIGIT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value,
    input  logic [4:0]  i_base,
    input  logic [6:0]  i_width,
    input  logic [6:0]  i_precision,
    input  logic [6:0]  i_format_flags,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_text_char,
    output logic        o_last,
    output logic        o_truncated
);
    import itf_pkg::*;

    t_item   push_item, head_item;
    t_q_stat q_stat;
    logic    q_push, q_pop;

    // front: classify, drop out of range bases (they give no text)
    itf_front u_front (
        .i_value        (i_value),
        .i_base         (i_base),
        .i_width        (i_width),
        .i_precision    (i_precision),
        .i_format_flags (i_format_flags),
        .i_valid        (i_valid),
        .i_q_stat       (q_stat),
        .o_stall        (o_stall),
        .o_push         (q_push),
        .o_item         (push_item)
    );

    // queue decouples the front from the slow back end
    itf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    // back: digits, layout, emission through an output register
    itf_back #(
        .MAX_CHARS   (MAX_CHARS),
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (head_item),
        .i_q_stat    (q_stat),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_text_char (o_text_char),
        .o_last      (o_last),
        .o_truncated (o_truncated)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full) else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty) else $error("queue pop while empty");

    a_trunc_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_truncated) |-> o_last) else $error("truncated flag off the last char");

endmodule

// ----- verif/integer_to_text_formatter_core_tb.sv -----
// Testbench for integer_to_text_formatter_core: directed and random integer requests,
// with every character checked against a formatter model held in this file.
// Depends on itf_pkg (flag bit positions, character codes) and the core RTL.
module integer_to_text_formatter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import itf_pkg::*;

    localparam int MAXC = 64;
    localparam int CYCLE_LIMIT = 3000000;

    // flag masks built from the package bit positions
    localparam logic [6:0] F_LEFT   = 7'(1 << FLAG_LJUST);
    localparam logic [6:0] F_PLUS   = 7'(1 << FLAG_FORCE_SIGN);
    localparam logic [6:0] F_SPACE  = 7'(1 << FLAG_BLANK_SIGN);
    localparam logic [6:0] F_PREFIX = 7'(1 << FLAG_PREFIX);
    localparam logic [6:0] F_ZPAD   = 7'(1 << FLAG_ZPAD);
    localparam logic [6:0] F_LOWER  = 7'(1 << FLAG_LOWER);
    localparam logic [6:0] F_SIGNED = 7'(1 << FLAG_SIGNED);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       trunc;
    } t_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [63:0] i_value = '0;
    logic [4:0]  i_base = 5'd10;
    logic [6:0]  i_width = '0;
    logic [6:0]  i_precision = '0;
    logic [6:0]  i_format_flags = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_text_char;
    logic        o_last;
    logic        o_truncated;

    integer_to_text_formatter_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_char  expected_chars[$];
    int     mismatches = 0;
    int     chars_seen = 0;
    int     requests_sent = 0;
    int     cycles = 0;
    int     send_idle_pct = 0;   // sender idle chance, percent
    int     recv_stall_pct = 0;  // receiver stall chance, percent
    bit     hold_recv = 1'b0;    // long receiver hold-off
    int     hold_cycles = 0;

    // Formatted text of one request, as printf would build it, capped at MAXC.
    task automatic format_text(input logic [63:0] v, input logic [4:0] b, input logic [6:0] w,
                               input logic [6:0] p, input logic [6:0] fl);
        byte    txt[$];
        byte    digs[$];
        byte    sgn;
        byte    pad;
        int     room;
        int     prec;
        int     total;
        logic [63:0] mag;
        bit     left;
        bit     zpad;
        bit     lower;
        t_char  c;
        begin
            if (b < 2 || b > 16) return;
            left = fl[FLAG_LJUST];
            lower = fl[FLAG_LOWER];
            zpad = fl[FLAG_ZPAD] && !left;
            room = w;
            mag = v;
            sgn = 0;
            if (fl[FLAG_SIGNED]) begin
                if (v[63]) begin
                    sgn = CH_MINUS;
                    mag = -v;
                end else if (fl[FLAG_FORCE_SIGN]) sgn = CH_PLUS;
                else if (fl[FLAG_BLANK_SIGN]) sgn = CH_SPACE;
                if (sgn != 0) room--;
            end
            if (fl[FLAG_PREFIX]) begin
                if (b == 16) room -= 2;
                else if (b == 8) room -= 1;
            end
            do begin
                logic [3:0] d;
                d = 4'(mag % b);
                digs.push_front(d < 10 ? byte'(CH_ZERO + d) :
                                byte'((lower ? 8'h61 : 8'h41) + d - 10));
                mag = mag / b;
            end while (mag != 0);
            prec = (p < digs.size()) ? digs.size() : p;
            room -= prec;
            if (!left && !zpad) while (room > 0) begin txt.push_back(CH_SPACE); room--; end
            if (sgn != 0) txt.push_back(sgn);
            if (fl[FLAG_PREFIX] && (b == 8 || b == 16)) begin
                txt.push_back(CH_ZERO);
                if (b == 16) txt.push_back(lower ? CH_X_LO : CH_X_UP);
            end
            if (!left) begin
                pad = zpad ? CH_ZERO : CH_SPACE;
                while (room > 0) begin txt.push_back(pad); room--; end
            end
            while (prec > digs.size()) begin txt.push_back(CH_ZERO); prec--; end
            foreach (digs[k]) txt.push_back(digs[k]);
            while (room > 0) begin txt.push_back(CH_SPACE); room--; end
            total = txt.size();
            for (int k = 0; k < total && k < MAXC; k++) begin
                c.ch = txt[k];
                c.last = (k == total - 1) || (k == MAXC - 1);
                c.trunc = c.last && (total > MAXC);
                expected_chars.push_back(c);
            end
        end
    endtask

    // Offer one request; idles first at the phase's rate, holds until taken.
    // Valid stays high afterwards so a following request can go back to back;
    // idling or wait_drained drops it.
    task automatic send_request(input logic [63:0] v, input logic [4:0] b, input logic [6:0] w,
                                input logic [6:0] p, input logic [6:0] fl);
        begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_value <= v;
            i_base <= b;
            i_width <= w;
            i_precision <= p;
            i_format_flags <= fl;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            format_text(v, b, w, p, fl);
            requests_sent++;
        end
    endtask

    task automatic wait_drained;
        begin
            i_valid <= 1'b0;
            while (expected_chars.size() != 0) @(posedge i_clk);
            repeat (400) @(posedge i_clk);
        end
    endtask

    // receiver stall and the long hold-off
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (hold_recv) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // character checker
    always @(posedge i_clk) begin
        t_char exp_c;
        if (i_rst_n && o_valid && !i_stall) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected character %h last=%b trunc=%b",
                             o_text_char, o_last, o_truncated);
            end else begin
                exp_c = expected_chars.pop_front();
                if (exp_c.ch !== o_text_char || exp_c.last !== o_last ||
                    exp_c.trunc !== o_truncated) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ch=%h last=%b trunc=%b, got %h %b %b",
                                 exp_c.ch, exp_c.last, exp_c.trunc,
                                 o_text_char, o_last, o_truncated);
                end
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand_value;
        logic [63:0] v;
        begin
            v = {$urandom, $urandom};
            case ($urandom_range(5))
                0: v = v & 64'hFF;
                1: v = 64'h8000_0000_0000_0000;
                2: v = 64'd0 - 64'($urandom_range(300));
                3: v = '1;
                default: ;
            endcase
            return v;
        end
    endfunction

    task automatic send_random(input int n);
        logic [4:0] b;
        logic [6:0] w;
        logic [6:0] p;
        begin
            repeat (n) begin
                b = ($urandom_range(19) == 0) ? 5'($urandom) : 5'($urandom_range(16, 2));
                w = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(24));
                p = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(20));
                send_request(rand_value(), b, w, p, 7'($urandom));
            end
        end
    endtask

    // extremes, each sign rule, prefixes, zero, bad bases, truncation
    task automatic test_directed;
        begin
            send_request(64'd0, 5'd10, 7'd0, 7'd0, 7'd0);
            send_request(64'd0, 5'd16, 7'd0, 7'd0, F_PREFIX | F_LOWER);
            send_request(64'd0, 5'd8, 7'd5, 7'd0, F_PREFIX | F_ZPAD);
            send_request(64'h8000_0000_0000_0000, 5'd10, 7'd0, 7'd0, F_SIGNED);
            send_request(64'h8000_0000_0000_0000, 5'd2, 7'd0, 7'd0, F_SIGNED);
            send_request('1, 5'd2, 7'd0, 7'd0, 7'd0);
            send_request('1, 5'd3, 7'd0, 7'd0, 7'd0);
            send_request('1, 5'd10, 7'd0, 7'd0, F_SIGNED | F_PLUS);
            send_request(64'd42, 5'd10, 7'd8, 7'd0, F_SIGNED | F_PLUS | F_SPACE);
            send_request(64'd42, 5'd10, 7'd8, 7'd0, F_SIGNED | F_SPACE | F_ZPAD);
            send_request(64'd42, 5'd10, 7'd8, 7'd4, F_LEFT | F_ZPAD | F_SIGNED | F_PLUS);
            send_request(64'hDEAD_BEEF, 5'd16, 7'd16, 7'd0, F_PREFIX | F_ZPAD);
            send_request(64'hDEAD_BEEF, 5'd16, 7'd16, 7'd10, F_PREFIX | F_LOWER | F_LEFT);
            send_request(64'o777, 5'd8, 7'd10, 7'd0, F_PREFIX);
            send_request(64'd255, 5'd7, 7'd0, 7'd0, F_PREFIX | F_PLUS | F_SPACE);
            send_request(64'd5, 5'd0, 7'd10, 7'd0, 7'd0);
            send_request(64'd5, 5'd1, 7'd10, 7'd0, 7'd0);
            send_request(64'd5, 5'd17, 7'd10, 7'd0, 7'd0);
            send_request(64'd5, 5'd31, 7'd10, 7'd0, 7'd0);
            send_request(64'd7, 5'd10, 7'd127, 7'd0, F_LEFT);
            send_request(64'd7, 5'd10, 7'd0, 7'd127, F_SIGNED | F_PLUS);
            send_request(64'd7, 5'd10, 7'd64, 7'd64, 7'h7F);
            send_request('1, 5'd16, 7'd127, 7'd127, 7'h7F);
            send_request(64'h1234, 5'd16, 7'd64, 7'd0, 7'd0);
            wait_drained();
        end
    endtask

    task automatic test_random_free_flow;
        begin
            send_idle_pct = 0; recv_stall_pct = 0;
            send_random(80);
            wait_drained();
        end
    endtask

    task automatic test_random_sender_idle;
        begin
            send_idle_pct = 84; recv_stall_pct = 0;
            send_random(60);
        end
    endtask

    task automatic test_random_receiver_stall;
        begin
            send_idle_pct = 0; recv_stall_pct = 84;
            send_random(60);
        end
    endtask

    task automatic test_random_both_light;
        begin
            send_idle_pct = 8; recv_stall_pct = 8;
            send_random(80);
            wait_drained();
        end
    endtask

    // receiver held off while requests keep coming, so the queue fills
    task automatic test_backpressure;
        begin
            send_idle_pct = 0; recv_stall_pct = 0;
            hold_recv = 1'b1;
            fork
                send_random(6);
                begin
                    repeat (300) @(posedge i_clk);
                    hold_recv = 1'b0;
                end
            join
            wait_drained();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_free_flow();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_light();
        test_backpressure();
        wait_drained();
        $display("Sent %0d requests, checked %0d characters; receiver held off %0d cycles.",
                 requests_sent, chars_seen, hold_cycles);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d characters outstanding", mismatches,
                     expected_chars.size());
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
